@@ src/kwtk_pkg.sv @@
package kwtk_pkg;

  localparam int WORKERS    = 8;
  localparam int LIST_DEPTH = 8;
  localparam int MAX_EMIT   = 64;

  localparam int WIDX_W = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int POS_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int FILL_W = $clog2(LIST_DEPTH + 1);
  localparam int ADDR_W = $clog2(WORKERS * LIST_DEPTH);
  localparam int TOT_W  = $clog2(WORKERS * LIST_DEPTH + 1);
  localparam int IDX_W  = 3;
  localparam int KEY_W  = 32;
  localparam int ROW_W  = 32;
  localparam int KEEP_W = 7;
  localparam int CFG_W  = 7;

  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_MERGE  = 1'b1;

  typedef enum logic {
    REG_KEEP_COUNT = 1'b0,
    REG_ASCENDING  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic              append;
    logic              scan_start;
    logic              scan_issue;
    logic [WIDX_W-1:0] scan_w;
    logic              emit;
    logic              clear;
  } cmd_t;

  typedef struct packed {
    logic limit_zero;
    logic empty;
    logic last;
  } status_t;

  // Map float bits to an unsigned code whose order follows float order.
  function automatic logic [KEY_W-1:0] order_key(input logic [KEY_W-1:0] b);
    logic [KEY_W-1:0] v;
    v = (b == 32'h8000_0000) ? '0 : b;
    order_key = v[KEY_W-1] ? ~v : (v | 32'h8000_0000);
  endfunction

endpackage

@@ src/kway_topk_merge.sv @@
// Load item: busy stays low, next item may follow at once.
// Merge item: each emitted pair is found by a scan that reads one list head per
// cycle from the pair memory, then a compare step and an output step; a final
// clearing step then empties the lists; busy is high throughout.
// Results are strobed on out_valid for one cycle; the receiver cannot stall.
// Synchronous active-low reset clears all lists, counts and configuration.
module kway_topk_merge (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_func,
  input  logic [kwtk_pkg::IDX_W-1:0] in_list_index,
  input  logic [kwtk_pkg::KEY_W-1:0] in_key_bits,
  input  logic [kwtk_pkg::ROW_W-1:0] in_row_id,
  output logic                       out_valid,
  output logic [kwtk_pkg::KEY_W-1:0] out_key_bits,
  output logic [kwtk_pkg::ROW_W-1:0] out_row_id,
  output logic                       out_is_last,
  output logic                       out_overflow_seen,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [kwtk_pkg::CFG_W-1:0] cfg_wdata
);

  kwtk_pkg::cmd_t    cmd;
  kwtk_pkg::status_t sts;

  kwtk_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  kwtk_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_list_index     (in_list_index),
    .in_key_bits       (in_key_bits),
    .in_row_id         (in_row_id),
    .out_key_bits      (out_key_bits),
    .out_row_id        (out_row_id),
    .out_is_last       (out_is_last),
    .out_overflow_seen (out_overflow_seen)
  );

  assign out_valid = cmd.emit;

endmodule

@@ src/kwtk_ctrl.sv @@
module kwtk_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_func,
  input  kwtk_pkg::status_t sts,
  output kwtk_pkg::cmd_t    cmd,
  output logic              busy
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_FIN   = 5'b00100,
    S_EMIT  = 5'b01000,
    S_CLEAR = 5'b10000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [kwtk_pkg::WIDX_W-1:0] w_r, w_nxt;

  always_comb begin
    state_nxt = state_r;
    w_nxt     = w_r;
    case (state_r)
      S_IDLE: begin
        w_nxt = '0;
        if (start && in_func == kwtk_pkg::FUNC_MERGE) begin
          state_nxt = (sts.limit_zero || sts.empty) ? S_CLEAR : S_SCAN;
        end
      end
      S_SCAN: begin
        if (32'(w_r) == kwtk_pkg::WORKERS - 1) begin
          state_nxt = S_FIN;
        end else begin
          w_nxt = w_r + 1'b1;
        end
      end
      S_FIN:  state_nxt = S_EMIT;
      S_EMIT: begin
        w_nxt     = '0;
        state_nxt = sts.last ? S_CLEAR : S_SCAN;
      end
      S_CLEAR: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      w_r     <= '0;
    end else begin
      state_r <= state_nxt;
      w_r     <= w_nxt;
    end
  end

  always_comb begin
    cmd.append     = (state_r == S_IDLE) && start && (in_func == kwtk_pkg::FUNC_APPEND);
    cmd.scan_issue = (state_r == S_SCAN);
    cmd.scan_start = (state_r == S_SCAN) && (w_r == '0);
    cmd.scan_w     = w_r;
    cmd.emit       = (state_r == S_EMIT);
    cmd.clear      = (state_r == S_CLEAR);
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ src/kwtk_dp.sv @@
module kwtk_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  kwtk_pkg::cmd_t              cmd,
  output kwtk_pkg::status_t           sts,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [kwtk_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic [kwtk_pkg::IDX_W-1:0]  in_list_index,
  input  logic [kwtk_pkg::KEY_W-1:0]  in_key_bits,
  input  logic [kwtk_pkg::ROW_W-1:0]  in_row_id,
  output logic [kwtk_pkg::KEY_W-1:0]  out_key_bits,
  output logic [kwtk_pkg::ROW_W-1:0]  out_row_id,
  output logic                        out_is_last,
  output logic                        out_overflow_seen
);

  localparam int NENT = kwtk_pkg::WORKERS * kwtk_pkg::LIST_DEPTH;

  logic [kwtk_pkg::KEY_W-1:0]  key_mem [NENT];
  logic [kwtk_pkg::ROW_W-1:0]  row_mem [NENT];

  logic [kwtk_pkg::FILL_W-1:0] fill_r [kwtk_pkg::WORKERS];
  logic [kwtk_pkg::FILL_W-1:0] cur_r  [kwtk_pkg::WORKERS];
  logic [kwtk_pkg::TOT_W-1:0]  total_r;
  logic [kwtk_pkg::KEEP_W-1:0] emitted_r;
  logic                        ovf_r;
  logic [kwtk_pkg::KEEP_W-1:0] keep_r;
  logic                        asc_r;

  logic [kwtk_pkg::KEY_W-1:0]  rd_key_r;
  logic [kwtk_pkg::ROW_W-1:0]  rd_row_r;
  logic                        rd_vld_r;
  logic [kwtk_pkg::WIDX_W-1:0] rd_w_r;

  logic [kwtk_pkg::KEY_W-1:0]  best_key_r, best_ord_r;
  logic [kwtk_pkg::ROW_W-1:0]  best_row_r;
  logic [kwtk_pkg::WIDX_W-1:0] best_w_r;
  logic                        found_r;

  logic [kwtk_pkg::WIDX_W-1:0] sel_w;
  logic [kwtk_pkg::FILL_W-1:0] sel_fill, sel_cur;
  logic                        in_ok, list_full;
  logic [kwtk_pkg::ADDR_W-1:0] wr_addr, rd_addr, base;
  logic [kwtk_pkg::KEEP_W-1:0] limit;
  logic [kwtk_pkg::KEY_W-1:0]  rd_ord;
  logic                        better;

  assign sel_w     = cmd.scan_issue ? cmd.scan_w : kwtk_pkg::WIDX_W'(in_list_index);
  assign sel_fill  = fill_r[sel_w];
  assign sel_cur   = cur_r[sel_w];
  assign in_ok     = 32'(in_list_index) < kwtk_pkg::WORKERS;
  assign list_full = 32'(sel_fill) >= kwtk_pkg::LIST_DEPTH;
  assign base      = kwtk_pkg::ADDR_W'(kwtk_pkg::ADDR_W'(sel_w) *
                                       kwtk_pkg::ADDR_W'(kwtk_pkg::LIST_DEPTH));
  assign wr_addr   = base + kwtk_pkg::ADDR_W'(kwtk_pkg::POS_W'(sel_fill));
  assign rd_addr   = base + kwtk_pkg::ADDR_W'(kwtk_pkg::POS_W'(sel_cur));

  assign limit = (32'(keep_r) > kwtk_pkg::MAX_EMIT) ? kwtk_pkg::KEEP_W'(kwtk_pkg::MAX_EMIT)
                                                     : keep_r;

  assign rd_ord = kwtk_pkg::order_key(rd_key_r);
  assign better = asc_r ? (rd_ord < best_ord_r) : (rd_ord > best_ord_r);

  always_ff @(posedge clk) begin
    if (cmd.append && in_ok && !list_full) begin
      key_mem[wr_addr] <= in_key_bits;
      row_mem[wr_addr] <= in_row_id;
    end
    rd_key_r <= key_mem[rd_addr];
    rd_row_r <= row_mem[rd_addr];
    rd_w_r   <= sel_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < kwtk_pkg::WORKERS; i++) begin
        fill_r[i] <= '0;
        cur_r[i]  <= '0;
      end
      total_r   <= '0;
      emitted_r <= '0;
      ovf_r     <= 1'b0;
      keep_r    <= '0;
      asc_r     <= 1'b0;
      rd_vld_r  <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          kwtk_pkg::REG_KEEP_COUNT: keep_r <= cfg_wdata;
          kwtk_pkg::REG_ASCENDING:  asc_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
      rd_vld_r <= cmd.scan_issue && (sel_cur < sel_fill);
      if (cmd.append && in_ok) begin
        if (list_full) begin
          ovf_r <= 1'b1;
        end else begin
          fill_r[sel_w] <= sel_fill + 1'b1;
          total_r       <= total_r + 1'b1;
        end
      end
      // Drop the previous winner when a new scan begins.
      if (cmd.scan_start) begin
        found_r <= 1'b0;
      end else if (rd_vld_r && (!found_r || better)) begin
        found_r <= 1'b1;
      end
      if (cmd.emit) begin
        cur_r[best_w_r] <= cur_r[best_w_r] + 1'b1;
        emitted_r       <= emitted_r + 1'b1;
      end
      if (cmd.clear) begin
        for (int i = 0; i < kwtk_pkg::WORKERS; i++) begin
          fill_r[i] <= '0;
          cur_r[i]  <= '0;
        end
        total_r   <= '0;
        emitted_r <= '0;
        ovf_r     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd.scan_start && rd_vld_r && (!found_r || better)) begin
      best_key_r <= rd_key_r;
      best_row_r <= rd_row_r;
      best_ord_r <= rd_ord;
      best_w_r   <= rd_w_r;
    end
  end

  always_comb begin
    sts.limit_zero = (limit == '0);
    sts.empty      = (total_r == '0);
    sts.last       = (32'(emitted_r) + 1 == 32'(limit)) ||
                     (32'(emitted_r) + 1 == 32'(total_r));
  end

  assign out_key_bits      = best_key_r;
  assign out_row_id        = best_row_r;
  assign out_is_last       = sts.last;
  assign out_overflow_seen = ovf_r;

endmodule

@@ src/kwtk_checker.sv @@
module kwtk_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_func,
  input logic out_valid,
  input logic out_is_last
);

  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");

  a_no_b2b: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("results in adjacent cycles");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_last) |=> ##1 !busy) else $error("busy after last result");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == kwtk_pkg::FUNC_APPEND) |=> !busy)
    else $error("load item made block busy");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid) else $error("not idle after reset");

endmodule

bind kway_topk_merge kwtk_checker u_kwtk_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_func     (in_func),
  .out_valid   (out_valid),
  .out_is_last (out_is_last)
);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [kwtk_pkg::KEY_W-1:0] key;
    logic [kwtk_pkg::ROW_W-1:0] row;
    logic                       last;
    logic                       ovf;
  } pair_res_t;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic                       in_func;
  logic [kwtk_pkg::IDX_W-1:0] in_list_index;
  logic [kwtk_pkg::KEY_W-1:0] in_key_bits;
  logic [kwtk_pkg::ROW_W-1:0] in_row_id;
  logic                       out_valid;
  logic [kwtk_pkg::KEY_W-1:0] out_key_bits;
  logic [kwtk_pkg::ROW_W-1:0] out_row_id;
  logic                       out_is_last;
  logic                       out_overflow_seen;
  logic                       cfg_we;
  logic                       cfg_index;
  logic [kwtk_pkg::CFG_W-1:0] cfg_wdata;

  // predictor state
  logic [kwtk_pkg::KEY_W-1:0] m_key [kwtk_pkg::WORKERS*kwtk_pkg::LIST_DEPTH];
  logic [kwtk_pkg::ROW_W-1:0] m_row [kwtk_pkg::WORKERS*kwtk_pkg::LIST_DEPTH];
  int                         m_fill [kwtk_pkg::WORKERS];
  logic                       m_ovf;
  int                         m_keep;
  logic                       m_asc;

  pair_res_t merged_q[$];
  int        errors;
  int        n_sent;
  longint    cycles;

  kway_topk_merge u_top (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 2000000) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic logic [kwtk_pkg::KEY_W-1:0] float_rank(logic [kwtk_pkg::KEY_W-1:0] b);
    logic [kwtk_pkg::KEY_W-1:0] v;
    v = (b == {1'b1, {(kwtk_pkg::KEY_W-1){1'b0}}}) ? '0 : b;
    return v[kwtk_pkg::KEY_W-1] ? ~v : {1'b1, v[kwtk_pkg::KEY_W-2:0]};
  endfunction

  function automatic void predict_item(logic f, logic [kwtk_pkg::IDX_W-1:0] li,
                                       logic [kwtk_pkg::KEY_W-1:0] k,
                                       logic [kwtk_pkg::ROW_W-1:0] r);
    int        cur [kwtk_pkg::WORKERS];
    int        limit;
    int        n;
    int        best;
    logic [kwtk_pkg::KEY_W-1:0] best_rank;
    logic [kwtk_pkg::KEY_W-1:0] rk;
    pair_res_t p;
    if (f == kwtk_pkg::FUNC_APPEND) begin
      if (li >= kwtk_pkg::WORKERS) return;
      if (m_fill[li] >= kwtk_pkg::LIST_DEPTH) begin
        m_ovf = 1'b1;
        return;
      end
      m_key[li*kwtk_pkg::LIST_DEPTH + m_fill[li]] = k;
      m_row[li*kwtk_pkg::LIST_DEPTH + m_fill[li]] = r;
      m_fill[li]++;
      return;
    end
    limit = (m_keep > kwtk_pkg::MAX_EMIT) ? kwtk_pkg::MAX_EMIT : m_keep;
    foreach (cur[w]) cur[w] = 0;
    n = 0;
    while (n < limit) begin
      best = -1;
      best_rank = '0;
      for (int w = 0; w < kwtk_pkg::WORKERS; w++) begin
        if (cur[w] >= m_fill[w]) continue;
        rk = float_rank(m_key[w*kwtk_pkg::LIST_DEPTH + cur[w]]);
        if (best < 0 || (m_asc ? (rk < best_rank) : (rk > best_rank))) begin
          best = w;
          best_rank = rk;
        end
      end
      if (best < 0) break;
      p.key  = m_key[best*kwtk_pkg::LIST_DEPTH + cur[best]];
      p.row  = m_row[best*kwtk_pkg::LIST_DEPTH + cur[best]];
      p.last = 1'b0;
      p.ovf  = m_ovf;
      merged_q.insert(merged_q.size(), p);
      cur[best]++;
      n++;
    end
    if (n > 0) merged_q[$].last = 1'b1;
    foreach (m_fill[w]) m_fill[w] = 0;
    m_ovf = 1'b0;
  endfunction

  // check each emitted pair against the oldest expectation
  initial begin
    pair_res_t e;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid) begin
        if (merged_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected pair key=%h row=%h", $time, out_key_bits, out_row_id);
        end else begin
          e = merged_q.pop_front();
          if (out_key_bits !== e.key) begin
            errors++;
            $display("%0t: key exp %h got %h", $time, e.key, out_key_bits);
          end
          if (out_row_id !== e.row) begin
            errors++;
            $display("%0t: row exp %h got %h", $time, e.row, out_row_id);
          end
          if (out_is_last !== e.last) begin
            errors++;
            $display("%0t: last exp %b got %b", $time, e.last, out_is_last);
          end
          if (out_overflow_seen !== e.ovf) begin
            errors++;
            $display("%0t: overflow exp %b got %b", $time, e.ovf, out_overflow_seen);
          end
        end
      end
    end
  end

  // start stays high from one item into the next when there is no gap
  task automatic send_item(logic f, logic [kwtk_pkg::IDX_W-1:0] li,
                           logic [kwtk_pkg::KEY_W-1:0] k,
                           logic [kwtk_pkg::ROW_W-1:0] r, bit gaps = 1);
    int gap;
    gap = gaps ? $urandom_range(0, 18) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_func       <= f;
    in_list_index <= li;
    in_key_bits   <= k;
    in_row_id     <= r;
    do @(posedge clk); while (busy);
    predict_item(f, li, k, r);
    n_sent++;
  endtask

  // drop start, wait out the merge: results drain, then the clearing cycle
  task automatic settle();
    start <= 1'b0;
    while (merged_q.size() != 0) @(posedge clk);
    repeat (kwtk_pkg::WORKERS + 6) @(posedge clk);
  endtask

  task automatic write_reg(kwtk_pkg::reg_idx_t idx, int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[kwtk_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    if (idx == kwtk_pkg::REG_KEEP_COUNT) m_keep = value & 8'h7f;
    else m_asc = value[0];
  endtask

  function automatic logic [kwtk_pkg::KEY_W-1:0] rand_key();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return {1'($urandom_range(0, 1)), 8'hff, 23'h0};
      3: return {1'($urandom_range(0, 1)), 8'h00, 23'($urandom)};
      default: return {1'($urandom_range(0, 1)), 8'($urandom_range(0, 254)), 23'($urandom)};
    endcase
  endfunction

  // build sorted lists under the current order, then merge
  task automatic load_sorted_and_merge(int max_per_list, bit gaps);
    logic [kwtk_pkg::KEY_W-1:0] ks[$];
    int n;
    for (int w = 0; w < kwtk_pkg::WORKERS; w++) begin
      n = $urandom_range(0, max_per_list);
      ks.delete();
      for (int i = 0; i < n; i++) ks.insert(ks.size(), rand_key());
      // equal-rank keys left unordered are fine: ties between lists are the point
      ks.sort() with (float_rank(item));
      if (!m_asc) ks.reverse();
      foreach (ks[i])
        send_item(kwtk_pkg::FUNC_APPEND, w[kwtk_pkg::IDX_W-1:0], ks[i], $urandom, gaps);
    end
    send_item(kwtk_pkg::FUNC_MERGE, kwtk_pkg::IDX_W'($urandom), $urandom, $urandom, gaps);
    settle();
  endtask

  task automatic test_directed();
    write_reg(kwtk_pkg::REG_KEEP_COUNT, 64);
    write_reg(kwtk_pkg::REG_ASCENDING, 1);
    // ties across lists, signed zeros, infinities, extremes of row id
    send_item(kwtk_pkg::FUNC_APPEND, 3'd2, 32'h8000_0000, 32'hffff_ffff);
    send_item(kwtk_pkg::FUNC_APPEND, 3'd1, 32'h0000_0000, 32'h0000_0000);
    send_item(kwtk_pkg::FUNC_APPEND, 3'd0, 32'hff80_0000, 32'h1234_5678);
    send_item(kwtk_pkg::FUNC_APPEND, 3'd0, 32'h3f80_0000, 32'haaaa_5555);
    send_item(kwtk_pkg::FUNC_APPEND, 3'd7, 32'h7f80_0000, 32'h5555_aaaa);
    send_item(kwtk_pkg::FUNC_APPEND, 3'd5, 32'h3f80_0000, 32'h0000_0001);
    send_item(kwtk_pkg::FUNC_MERGE, 3'd7, 32'hffff_ffff, 32'hffff_ffff);
    settle();
    // overflow one list, emit only three
    write_reg(kwtk_pkg::REG_KEEP_COUNT, 3);
    write_reg(kwtk_pkg::REG_ASCENDING, 0);
    for (int i = 0; i < kwtk_pkg::LIST_DEPTH + 2; i++)
      send_item(kwtk_pkg::FUNC_APPEND, 3'd6, 32'h4000_0000 - i, i, 1'b0);
    send_item(kwtk_pkg::FUNC_MERGE, 3'd0, 32'h0, 32'h0);
    settle();
    // keep of zero still empties lists; merge of empty lists emits nothing
    write_reg(kwtk_pkg::REG_KEEP_COUNT, 0);
    send_item(kwtk_pkg::FUNC_APPEND, 3'd3, 32'h4120_0000, 32'h77);
    send_item(kwtk_pkg::FUNC_MERGE, 3'd0, 32'h0, 32'h0);
    settle();
    write_reg(kwtk_pkg::REG_KEEP_COUNT, 127);
    send_item(kwtk_pkg::FUNC_MERGE, 3'd0, 32'h0, 32'h0);
    settle();
  endtask

  task automatic test_random();
    while (n_sent < 250) begin
      case ($urandom_range(0, 3))
        0: write_reg(kwtk_pkg::REG_KEEP_COUNT, $urandom_range(0, 127));
        1: write_reg(kwtk_pkg::REG_KEEP_COUNT, $urandom_range(1, 20));
        default: write_reg(kwtk_pkg::REG_KEEP_COUNT, 64);
      endcase
      write_reg(kwtk_pkg::REG_ASCENDING, $urandom_range(0, 1));
      if ($urandom_range(0, 5) == 0) begin
        // noise: unsorted pairs, overflowing lists
        for (int i = 0; i < 12; i++)
          send_item(kwtk_pkg::FUNC_APPEND, kwtk_pkg::IDX_W'($urandom), $urandom, $urandom,
                    1'($urandom_range(0, 1)));
        send_item(kwtk_pkg::FUNC_MERGE, kwtk_pkg::IDX_W'($urandom), $urandom, $urandom);
        settle();
      end else begin
        load_sorted_and_merge($urandom_range(0, 1) ? 3 : kwtk_pkg::LIST_DEPTH,
                              $urandom_range(0, 2) != 0);
      end
    end
  endtask

  initial begin
    errors = 0;
    n_sent = 0;
    m_keep = 0;
    m_asc = 1'b0;
    m_ovf = 1'b0;
    foreach (m_fill[w]) m_fill[w] = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_func = kwtk_pkg::FUNC_APPEND;
    in_list_index = '0;
    in_key_bits = '0;
    in_row_id = '0;
    cfg_we = 1'b0;
    cfg_index = kwtk_pkg::REG_KEEP_COUNT;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    settle();
    if (errors == 0 && merged_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
